// ----- rtl/ibfs_pkg.sv -----
// shared types and constants for the icp burst frame serializer
package ibfs_pkg;

  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned FLAT_W     = 17;
  localparam int unsigned HDR_BITS   = 24;
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned SLOT_IDX_W = 6;
  localparam int unsigned PADDR_W    = 3;

  localparam logic [7:0] CMD_PROG_MAIN = 8'h21;
  localparam logic [7:0] CMD_PROG_BOOT = 8'h61;
  localparam logic [7:0] CMD_READ_MAIN = 8'h00;
  localparam logic [7:0] CMD_READ_BOOT = 8'h40;

  // register select is paddr[2]
  localparam logic REG_TRANSFER_MODE = 1'b0;

  localparam logic MODE_PROGRAM = 1'b0;
  localparam logic MODE_READ    = 1'b1;

  // slot positions inside a frame
  localparam logic [SLOT_IDX_W-1:0] IDX_FIRST_HDR  = 6'd0;
  localparam logic [SLOT_IDX_W-1:0] IDX_FIRST_DATA = 6'd24;
  localparam logic [SLOT_IDX_W-1:0] IDX_LAST_DATA  = 6'd31;
  localparam logic [SLOT_IDX_W-1:0] IDX_ACK        = 6'd32;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ACK    = 2'd2
  } slot_kind_t;

  typedef enum logic [1:0] {
    PAUSE_NONE  = 2'd0,
    PAUSE_SHORT = 2'd1,
    PAUSE_LONG  = 2'd2
  } pause_t;

  typedef struct packed {
    logic              restart;
    logic [FLAT_W-1:0] flat_address;
    logic [7:0]        write_byte;
    logic              final_byte;
  } item_t;

  typedef struct packed {
    logic       drive_line;
    logic       data_bit;
    logic [1:0] slot_kind;
    logic [1:0] pause_after;
    logic       last;
  } slot_t;

  typedef struct packed {
    logic                has_hdr;
    logic [HDR_BITS-1:0] hdr;
    logic [7:0]          data;
    logic                reading;
    logic                ack;
  } frame_t;

endpackage

// ----- rtl/icp_burst_frame_serializer_top.sv -----
// top level of the icp burst frame serializer
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+----------------------
//  item     | in        | item_valid / item_ready | ibfs_pkg::item_t
//  slot     | out       | slot_valid / slot_ready | ibfs_pkg::slot_t
//  apb      | in        | psel, penable, pready   | transfer_mode at 0x0
//
// one slot a cycle unless slot_ready stalls it: 33 slots per byte that opens a burst, 9 for the rest
// the next byte is taken in the cycle its predecessor's ack slot is issued
// the slot counter of the serializer sets the rate
// a slot stalled on slot_ready holds the serializer; nothing is dropped
// synchronous reset clears the mode, address, region, burst position and valids
module icp_burst_frame_serializer_top #(
  parameter int unsigned BURST_BYTES = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  ibfs_pkg::item_t               item,
  output logic                          slot_valid,
  input  logic                          slot_ready,
  output ibfs_pkg::slot_t               slot,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ibfs_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic             transfer_mode;
  logic             take;
  ibfs_pkg::frame_t frame;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_mode <= ibfs_pkg::MODE_PROGRAM;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ibfs_pkg::REG_TRANSFER_MODE) begin
      transfer_mode <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == ibfs_pkg::REG_TRANSFER_MODE) ? {31'b0, transfer_mode} : 32'b0;

  ibfs_frame #(
    .BURST_BYTES (BURST_BYTES)
  ) u_frame (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .item          (item),
    .transfer_mode (transfer_mode),
    .frame         (frame)
  );

  ibfs_shift u_shift (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .take       (take),
    .frame_in   (frame),
    .slot_valid (slot_valid),
    .slot_ready (slot_ready),
    .slot       (slot)
  );

endmodule

// ----- rtl/ibfs_frame.sv -----
// frame builder: burst state, command and header packing for one byte
module ibfs_frame #(
  parameter int unsigned BURST_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  ibfs_pkg::item_t   item,
  input  logic              transfer_mode,
  output ibfs_pkg::frame_t  frame
);

  localparam int unsigned POS_W = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BURST_BYTES - 1);

  logic [ibfs_pkg::ADDR_W-1:0] next_address;
  logic                        boot_region;
  logic [POS_W-1:0]            burst_position;

  logic [ibfs_pkg::ADDR_W-1:0] addr;
  logic                        boot;
  logic [POS_W-1:0]            pos;
  logic [7:0]                  cmd;
  logic                        ack;

  always_comb begin
    addr = item.restart ? item.flat_address[ibfs_pkg::ADDR_W-1:0] : next_address;
    boot = item.restart ? item.flat_address[ibfs_pkg::FLAT_W-1] : boot_region;
    pos  = item.restart ? '0 : burst_position;
    if (transfer_mode == ibfs_pkg::MODE_READ) begin
      cmd = boot ? ibfs_pkg::CMD_READ_BOOT : ibfs_pkg::CMD_READ_MAIN;
    end else begin
      cmd = boot ? ibfs_pkg::CMD_PROG_BOOT : ibfs_pkg::CMD_PROG_MAIN;
    end
    ack = (pos == POS_LAST) || item.final_byte;

    frame.has_hdr = (pos == '0);
    frame.hdr     = {cmd[7:6], addr[15:10], addr[9:2], addr[1:0], cmd[5:0]};
    frame.data    = item.write_byte;
    frame.reading = (transfer_mode == ibfs_pkg::MODE_READ);
    frame.ack     = ack;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_address   <= '0;
      boot_region    <= 1'b0;
      burst_position <= '0;
    end else if (take) begin
      next_address   <= addr + ibfs_pkg::ADDR_W'(1);
      boot_region    <= boot;
      burst_position <= ack ? '0 : pos + POS_W'(1);
    end
  end

endmodule

// ----- rtl/ibfs_shift.sv -----
// slot serializer: holds one frame and puts out one registered slot a cycle unless slot_ready stalls it
module ibfs_shift (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  output logic              take,
  input  ibfs_pkg::frame_t  frame_in,
  output logic              slot_valid,
  input  logic              slot_ready,
  output ibfs_pkg::slot_t   slot
);

  ibfs_pkg::frame_t                frame;
  logic                            frame_valid;
  logic [ibfs_pkg::SLOT_IDX_W-1:0] idx;

  logic                            step;
  logic                            frame_done;
  logic [4:0]                      hdr_sel;
  logic [2:0]                      data_sel;
  ibfs_pkg::slot_t                 slot_next;

  assign step       = frame_valid && (!slot_valid || slot_ready);
  assign frame_done = step && (idx == ibfs_pkg::IDX_ACK);
  assign item_ready = !frame_valid || frame_done;
  assign take       = item_valid && item_ready;

  assign hdr_sel  = 5'(ibfs_pkg::HDR_BITS - 1) - idx[4:0];
  assign data_sel = 3'(ibfs_pkg::IDX_LAST_DATA - idx);

  always_comb begin
    slot_next = '0;
    if (idx == ibfs_pkg::IDX_ACK) begin
      slot_next.drive_line  = 1'b1;
      slot_next.data_bit    = frame.ack;
      slot_next.slot_kind   = ibfs_pkg::KIND_ACK;
      slot_next.pause_after = frame.ack ? ibfs_pkg::PAUSE_LONG : ibfs_pkg::PAUSE_NONE;
      slot_next.last        = 1'b1;
    end else if (idx >= ibfs_pkg::IDX_FIRST_DATA) begin
      slot_next.drive_line  = !frame.reading;
      slot_next.data_bit    = !frame.reading && frame.data[data_sel];
      slot_next.slot_kind   = ibfs_pkg::KIND_DATA;
      slot_next.pause_after = (idx == ibfs_pkg::IDX_LAST_DATA && !frame.reading)
                              ? ibfs_pkg::PAUSE_SHORT : ibfs_pkg::PAUSE_NONE;
    end else begin
      slot_next.drive_line  = 1'b1;
      slot_next.data_bit    = frame.hdr[hdr_sel];
      slot_next.slot_kind   = ibfs_pkg::KIND_HEADER;
      slot_next.pause_after = ibfs_pkg::PAUSE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      slot_valid  <= 1'b0;
      idx         <= ibfs_pkg::IDX_FIRST_HDR;
    end else begin
      if (take) begin
        frame_valid <= 1'b1;
        idx <= frame_in.has_hdr ? ibfs_pkg::IDX_FIRST_HDR : ibfs_pkg::IDX_FIRST_DATA;
      end else if (frame_done) begin
        frame_valid <= 1'b0;
      end else if (step) begin
        idx <= idx + ibfs_pkg::SLOT_IDX_W'(1);
      end
      if (step) begin
        slot_valid <= 1'b1;
      end else if (slot_ready) begin
        slot_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame <= frame_in;
    end
    if (step) begin
      slot <= slot_next;
    end
  end

endmodule

// ----- rtl/ibfs_checker.sv -----
// port checker for the icp burst frame serializer, bound to the top level
module ibfs_checker (
  input logic            clk,
  input logic            rst,
  input logic            slot_valid,
  input logic            slot_ready,
  input ibfs_pkg::slot_t slot
);

  a_slot_hold: assert property (@(posedge clk) disable iff (rst)
    slot_valid && !slot_ready |=> slot_valid && $stable(slot))
    else $error("stalled slot changed");

  a_last_is_ack: assert property (@(posedge clk) disable iff (rst)
    slot_valid |-> (slot.last == (slot.slot_kind == ibfs_pkg::KIND_ACK)))
    else $error("last flag does not match ack slot");

  a_long_pause: assert property (@(posedge clk) disable iff (rst)
    slot_valid && slot.pause_after == ibfs_pkg::PAUSE_LONG |->
      slot.slot_kind == ibfs_pkg::KIND_ACK && slot.data_bit)
    else $error("long pause outside a set ack");

  a_released_low: assert property (@(posedge clk) disable iff (rst)
    slot_valid && !slot.drive_line |->
      !slot.data_bit && slot.slot_kind == ibfs_pkg::KIND_DATA)
    else $error("released slot carries a level");

endmodule

bind icp_burst_frame_serializer_top ibfs_checker u_ibfs_checker (
  .clk        (clk),
  .rst        (rst),
  .slot_valid (slot_valid),
  .slot_ready (slot_ready),
  .slot       (slot)
);
